// ===== rtl/crlfu8_pkg.sv =====
// Shared types and constants for the CR/LF normalising UTF-8 transcoder.
package crlfu8_pkg;

   localparam int unsigned MAX_BYTES = 5;

   localparam logic [2:0] FMT_BYTES   = 3'd0;
   localparam logic [2:0] FMT_UTF16BE = 3'd1;
   localparam logic [2:0] FMT_UTF16LE = 3'd2;
   localparam logic [2:0] FMT_UTF32BE = 3'd3;
   localparam logic [2:0] FMT_UTF32LE = 3'd4;

   localparam logic [7:0] CHAR_CR = 8'd13;
   localparam logic [7:0] CHAR_LF = 8'd10;

   typedef struct packed {
      logic       err;
      logic [7:0] data;
   } entry_type;

   typedef struct packed {
      entry_type [MAX_BYTES-1:0] ent;
      logic [2:0]                cnt;
   } burst_type;

endpackage

// ===== rtl/crlf_strip_utf8_transcoder.sv =====
// Top level of the CR/LF normalising UTF-8 transcoder.
// Each item is decoded in the cycle it is accepted and its bytes (none to five) land in a
// result register that drains one byte per cycle while rsp_tready is high. Items giving
// no byte or one byte stream back to back while the output is not stalled; an item giving
// more bytes holds the input until the single-byte result port has taken its last byte.
// A new item is taken in the same cycle as the last byte of the previous one. A CR
// gives no byte until the next item shows whether an LF follows. The user must write
// input_format through csr_we/csr_wdata only while the block is idle; the block does not enforce it.
module crlf_strip_utf8_transcoder
   import crlfu8_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [2:0]  csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // code_unit
   input  logic        req_tlast,   // end_of_data
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // out_byte
   output logic        rsp_tlast,   // last
   output logic        rsp_tuser    // error
);

   logic [2:0] input_format_ff;
   logic       accept;
   burst_type  dec_burst;

   assign accept = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         input_format_ff <= FMT_BYTES;
      end else if (csr_we) begin
         input_format_ff <= csr_wdata;
      end
   end

   crlfu8_decode u_decode (
      .clock        (clock),
      .reset        (reset),
      .input_format (input_format_ff),
      .accept       (accept),
      .code_unit    (req_tdata),
      .end_of_data  (req_tlast),
      .burst        (dec_burst)
   );

   crlfu8_burst u_burst (
      .clock      (clock),
      .reset      (reset),
      .load       (accept),
      .burst      (dec_burst),
      .load_ready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   a_burst_fits: assert property (@(posedge clock) disable iff (reset)
      accept |-> dec_burst.cnt <= 3'd5)
      else $error("byte list overflow");

   a_ready_only_when_drained: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> (!rsp_tvalid || (rsp_tready && rsp_tlast)))
      else $error("input taken while bytes still pending");

   a_error_byte_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> rsp_tdata == 8'h00)
      else $error("error item with non-zero byte");

   a_idle_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid straight after reset");

endmodule

// ===== rtl/crlfu8_decode.sv =====
// Unit decoder: line-ending and surrogate state, builds the byte list for one item.
module crlfu8_decode
   import crlfu8_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic [2:0]  input_format,
   input  logic        accept,
   input  logic [31:0] code_unit,
   input  logic        end_of_data,
   output burst_type   burst
);

   logic       cr_pending_ff, cr_pending_in;
   logic       hs_valid_ff, hs_valid_in;
   logic [9:0] hs_bits_ff, hs_bits_in;

   function automatic burst_type push(burst_type b, logic err, logic [7:0] d);
      burst_type r;
      r = b;
      r.ent[b.cnt] = '{err: err, data: d};
      r.cnt = b.cnt + 3'd1;
      return r;
   endfunction

   always_comb begin
      burst_type   b;
      logic        cr;
      logic        hsv;
      logic [9:0]  hsb;
      logic        drop;
      logic        flush;
      logic        do_err;
      logic        do_char;
      logic        set_hs;
      logic        raw;
      logic [20:0] ch;
      logic [15:0] w;
      logic [31:0] c;

      b       = '0;
      cr      = cr_pending_ff;
      hsv     = hs_valid_ff;
      hsb     = hs_bits_ff;
      drop    = 1'b0;
      flush   = 1'b0;
      do_err  = 1'b0;
      do_char = 1'b0;
      set_hs  = 1'b0;
      raw     = 1'b0;
      ch      = '0;
      w       = (input_format == FMT_UTF16LE) ? {code_unit[7:0], code_unit[15:8]}
                                              : code_unit[15:0];
      c       = (input_format == FMT_UTF32LE) ?
                {code_unit[7:0], code_unit[15:8], code_unit[23:16], code_unit[31:24]}
                : code_unit;

      if (end_of_data) begin
         drop  = 1'b1;
         flush = 1'b1;
      end else if (input_format == FMT_UTF16BE || input_format == FMT_UTF16LE) begin
         if (w inside {[16'hDC00:16'hDFFF]}) begin
            if (hsv) begin
               ch      = 21'h10000 + {1'b0, hsb, w[9:0]};
               hsv     = 1'b0;
               hsb     = '0;
               do_char = 1'b1;
            end else begin
               do_err = 1'b1;
            end
         end else begin
            drop = 1'b1;
            if (w inside {[16'hD800:16'hDBFF]}) begin
               flush  = 1'b1;
               set_hs = 1'b1;
            end else begin
               ch      = {5'd0, w};
               do_char = 1'b1;
            end
         end
      end else if (input_format == FMT_UTF32BE || input_format == FMT_UTF32LE) begin
         drop = 1'b1;
         if (c > 32'h0010_FFFF || (c inside {[32'hD800:32'hDFFF]})) begin
            do_err = 1'b1;
         end else begin
            ch      = c[20:0];
            do_char = 1'b1;
         end
      end else begin
         drop    = 1'b1;
         raw     = 1'b1;
         ch      = {13'd0, code_unit[7:0]};
         do_char = 1'b1;
      end

      // unpaired high surrogate
      if (drop && hsv) begin
         if (cr) begin
            b  = push(b, 1'b0, CHAR_LF);
            cr = 1'b0;
         end
         b   = push(b, 1'b1, 8'h00);
         hsv = 1'b0;
         hsb = '0;
      end

      if ((flush || do_err) && cr) begin
         b  = push(b, 1'b0, CHAR_LF);
         cr = 1'b0;
      end

      if (do_err) begin
         b = push(b, 1'b1, 8'h00);
      end

      if (set_hs) begin
         hsv = 1'b1;
         hsb = w[9:0];
      end

      if (do_char) begin
         if (cr) begin
            b  = push(b, 1'b0, CHAR_LF);
            cr = 1'b0;
            if (ch == {13'd0, CHAR_LF}) begin
               do_char = 1'b0;
            end
         end
         if (do_char && ch == {13'd0, CHAR_CR}) begin
            cr      = 1'b1;
            do_char = 1'b0;
         end
         if (do_char) begin
            if (raw || ch < 21'h80) begin
               b = push(b, 1'b0, ch[7:0]);
            end else if (ch < 21'h800) begin
               b = push(b, 1'b0, {3'b110, ch[10:6]});
               b = push(b, 1'b0, {2'b10, ch[5:0]});
            end else if (ch < 21'h10000) begin
               b = push(b, 1'b0, {4'b1110, ch[15:12]});
               b = push(b, 1'b0, {2'b10, ch[11:6]});
               b = push(b, 1'b0, {2'b10, ch[5:0]});
            end else begin
               b = push(b, 1'b0, {5'b11110, ch[20:18]});
               b = push(b, 1'b0, {2'b10, ch[17:12]});
               b = push(b, 1'b0, {2'b10, ch[11:6]});
               b = push(b, 1'b0, {2'b10, ch[5:0]});
            end
         end
      end

      burst         = b;
      cr_pending_in = cr;
      hs_valid_in   = hsv;
      hs_bits_in    = hsb;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cr_pending_ff <= 1'b0;
         hs_valid_ff   <= 1'b0;
         hs_bits_ff    <= '0;
      end else if (accept) begin
         cr_pending_ff <= cr_pending_in;
         hs_valid_ff   <= hs_valid_in;
         hs_bits_ff    <= hs_bits_in;
      end
   end

endmodule

// ===== rtl/crlfu8_burst.sv =====
// Result register: holds one item's byte list and hands it out a byte per cycle while rsp_tready is high.
module crlfu8_burst
   import crlfu8_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  burst_type  burst,
   output logic       load_ready,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,
   output logic       rsp_tlast,
   output logic       rsp_tuser
);

   entry_type [MAX_BYTES-1:0] ent_ff;
   logic [2:0]                cnt_ff;
   logic [2:0]                idx_ff, idx_in;
   logic                      last_byte;
   logic                      done;

   assign rsp_tvalid = (idx_ff != cnt_ff);
   assign last_byte  = (idx_ff == cnt_ff - 3'd1);
   assign done       = rsp_tvalid && rsp_tready && last_byte;
   assign load_ready = !rsp_tvalid || done;
   assign idx_in     = (rsp_tvalid && rsp_tready) ? idx_ff + 3'd1 : idx_ff;

   assign rsp_tdata = ent_ff[idx_ff].data;
   assign rsp_tuser = ent_ff[idx_ff].err;
   assign rsp_tlast = last_byte;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         idx_ff <= '0;
      end else if (load) begin
         cnt_ff <= burst.cnt;
         idx_ff <= '0;
      end else begin
         idx_ff <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         ent_ff <= burst.ent;
      end
   end

endmodule
